@@ design/bb3_pkg.sv @@
// ============================================================================
// bb3_pkg
// Shared limits, widths, register indexes, word kinds, the lane numerator
// type and the divider status type for the edge-aware 3x3 box blur.
// ============================================================================
package bb3_pkg;

   // Default frame limits handed to the top level.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Pixel and arithmetic widths.
   localparam int PIX_W     = 8;
   localparam int CH_N      = 3;
   localparam int PIX_BUS_W = CH_N * PIX_W;
   localparam int NB_N      = 9;                   // neighbors in a 3x3 window
   localparam int SUM_W     = 12;                  // up to 9 * 255
   localparam int CNT_W     = 4;                   // neighbor count 0..9
   localparam int NUM_W     = 13;                  // 2 * sum + count
   localparam int DEN_W     = 5;                   // 2 * count
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // Configuration port.
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

   // Input word kinds carried on tuser.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Per-lane numerators handed to the divider.
   typedef logic [CH_N-1:0][NUM_W-1:0] lane_num_type;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ design/bb3_div.sv @@
// ============================================================================
// bb3_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ============================================================================
module bb3_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bb3_pkg::lane_num_type  num,
   input  logic [bb3_pkg::DEN_W-1:0] den,
   output bb3_pkg::lane_num_type  quot,
   output bb3_pkg::div_stat_type  stat
);

   bb3_pkg::lane_num_type num_ff;
   bb3_pkg::lane_num_type quo_ff;
   logic [bb3_pkg::CH_N-1:0][bb3_pkg::DEN_W-1:0] rem_ff;
   logic [bb3_pkg::DEN_W-1:0] den_ff;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [bb3_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;

   logic [bb3_pkg::CH_N-1:0][bb3_pkg::DEN_W:0] shift_w;
   logic [bb3_pkg::CH_N-1:0][bb3_pkg::DEN_W:0] diff_w;
   logic [bb3_pkg::CH_N-1:0]                   ge_w;

   // One restoring step per lane: bring down the next numerator bit.
   always_comb begin
      for (int i = 0; i < bb3_pkg::CH_N; i++) begin
         shift_w[i] = {rem_ff[i], num_ff[i][bb3_pkg::NUM_W-1]};
         diff_w[i]  = shift_w[i] - {1'b0, den_ff};
         ge_w[i]    = (shift_w[i] >= {1'b0, den_ff});
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         for (int i = 0; i < bb3_pkg::CH_N; i++) begin
            num_ff[i] <= {num_ff[i][bb3_pkg::NUM_W-2:0], 1'b0};
            quo_ff[i] <= {quo_ff[i][bb3_pkg::NUM_W-2:0], ge_w[i]};
            rem_ff[i] <= ge_w[i] ? diff_w[i][bb3_pkg::DEN_W-1:0]
                                 : shift_w[i][bb3_pkg::DEN_W-1:0];
         end
      end
   end

   // Step counter and status.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = bb3_pkg::DIV_CNT_W'(bb3_pkg::NUM_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - bb3_pkg::DIV_CNT_W'(1);
         if (cnt_ff == bb3_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ design/box_blur_3x3_edge_aware.sv @@
// ============================================================================
// box_blur_3x3_edge_aware
// Edge-aware 3x3 box blur over a raster-order RGB pixel stream.
// ============================================================================
// Usage:
//   Pixels enter on the req_ stream in raster order; req_tuser selects a
//   pixel word or a drain tick. Each output word on rsp_ is a pixel replaced
//   by the rounded mean of its in-frame 3x3 neighbors. The result for raster
//   index p leaves on pixel input p+W+1; once the whole frame has arrived,
//   drain ticks flush the remaining results and rsp_tlast marks the final one.
//   Frame size is written on the csr_ port between frames.
//   Sequencing: a word that produces no result is taken in its accepting
//   cycle. A word that produces a result passes the accepting cycle, nine
//   read steps on the line store's single read port, the accumulate and
//   load steps, a 13-step restoring divider and the cycle that flags it
//   finished, then the hand-over to the output register; no new word is
//   taken until that hand-over.
//   Reset clears all positions and sets the frame to 1x1; the line store is
//   not cleared and needs no clearing pass. When the receiver stalls, the
//   output register holds its word and the next input word is still taken;
//   the block waits only when that word has a result to deliver.
// ============================================================================
module box_blur_3x3_edge_aware #(
   parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bb3_pkg::PIX_BUS_W-1:0]     req_tdata,   // blue_in, green_in, red_in
   input  logic [0:0]                        req_tuser,   // kind
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bb3_pkg::PIX_BUS_W-1:0]     rsp_tdata,   // blue_out, green_out, red_out
   output logic                              rsp_tlast,
   // Configuration.
   input  logic                              csr_we,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ColW  = $clog2(MAX_WIDTH);
   localparam int WEW   = $clog2(MAX_WIDTH + 1);
   localparam int WEX   = WEW + 1;
   localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HEW   = $clog2(MAX_HEIGHT + 1);
   localparam int HEX   = HEW + 1;
   localparam int Depth = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(Depth);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_SUM  = 6'b000100,
      ST_LOAD = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SEL_NONE = 2'd0,
      SEL_MEM  = 2'd1,
      SEL_BYP  = 2'd2
   } sel_type;

   // Store address of a row slot (row mod 3) and a column.
   function automatic logic [AW-1:0] line_addr(input logic [1:0] m3,
                                                input logic [ColW-1:0] col);
      logic [AW-1:0] base;
      case (m3)
         2'd1:    base = AW'(MAX_WIDTH);
         2'd2:    base = AW'(2 * MAX_WIDTH);
         default: base = '0;
      endcase
      return base + AW'(col);
   endfunction

   // Row slot of the neighbor row selected by d (0 above, 1 same, 2 below).
   function automatic logic [1:0] slot_offset(input logic [1:0] m3,
                                              input logic [1:0] d);
      logic [1:0] r;
      case (d)
         2'd0:    r = (m3 == 2'd0) ? 2'd2 : m3 - 2'd1;
         2'd1:    r = m3;
         default: r = (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] slot_next(input logic [1:0] m3);
      return (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
   endfunction

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                  state_ff, state_in;
   logic [WEW-1:0]             eff_w_ff, eff_w_in;
   logic [HEW-1:0]             eff_h_ff, eff_h_in;

   logic [RowW-1:0]            in_row_ff, in_row_in;
   logic [ColW-1:0]            in_col_ff, in_col_in;
   logic [1:0]                 in_m3_ff, in_m3_in;
   logic [RowW-1:0]            out_row_ff, out_row_in;
   logic [ColW-1:0]            out_col_ff, out_col_in;
   logic [1:0]                 out_m3_ff, out_m3_in;
   logic                       frame_done_ff, frame_done_in;

   logic                       kind_ff;
   logic [bb3_pkg::PIX_BUS_W-1:0] pix_ff;
   logic [1:0]                 dr_ff, dr_in;
   logic [1:0]                 dc_ff, dc_in;
   sel_type                    rd_sel_ff, rd_sel_in;
   logic [bb3_pkg::PIX_BUS_W-1:0] rd_data_ff;
   logic [bb3_pkg::CH_N-1:0][bb3_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [bb3_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [bb3_pkg::PIX_BUS_W-1:0] rsp_tdata_ff;
   logic                       rsp_tlast_ff;

   logic [bb3_pkg::PIX_BUS_W-1:0] line_mem [Depth];

   // ---------------------------------------------------------------------
   // Handshake and item decode
   // ---------------------------------------------------------------------
   logic req_fire, req_kind, emit_pos, need_blur, plain_write;
   logic out_free, done_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_kind   = req_tuser[0];
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;
   assign done_fire  = (state_ff == ST_DONE) & out_free;

   // A pixel yields a result once W+1 pixels of the frame have arrived.
   assign emit_pos = (HEX'(in_row_ff) >= HEX'(2)) ||
                     ((HEX'(in_row_ff) == HEX'(1)) && (in_col_ff != '0)) ||
                     ((in_row_ff == '0) &&
                      (WEX'(in_col_ff) >= WEX'(eff_w_ff) + WEX'(1)));

   assign need_blur   = (req_kind == bb3_pkg::KIND_DRAIN) ? frame_done_ff
                                                          : (~frame_done_ff & emit_pos);
   assign plain_write = req_fire & (req_kind == bb3_pkg::KIND_PIXEL) &
                        ~frame_done_ff & ~emit_pos;

   // ---------------------------------------------------------------------
   // Raster position stepping
   // ---------------------------------------------------------------------
   logic            in_col_end, in_row_end, in_wrap;
   logic            out_col_end, out_row_end, out_wrap;
   logic [RowW-1:0] in_row_nx, out_row_nx;
   logic [ColW-1:0] in_col_nx, out_col_nx;
   logic [1:0]      in_m3_nx, out_m3_nx;

   always_comb begin
      in_col_end = (WEX'(in_col_ff) + WEX'(1) >= WEX'(eff_w_ff));
      in_row_end = (HEX'(in_row_ff) + HEX'(1) >= HEX'(eff_h_ff));
      in_wrap    = in_col_end & in_row_end;
      in_row_nx  = in_row_ff;
      in_m3_nx   = in_m3_ff;
      in_col_nx  = in_col_ff + ColW'(1);
      if (in_col_end) begin
         in_col_nx = '0;
         if (in_row_end) begin
            in_row_nx = '0;
            in_m3_nx  = 2'd0;
         end else begin
            in_row_nx = in_row_ff + RowW'(1);
            in_m3_nx  = slot_next(in_m3_ff);
         end
      end
   end

   always_comb begin
      out_col_end = (WEX'(out_col_ff) + WEX'(1) >= WEX'(eff_w_ff));
      out_row_end = (HEX'(out_row_ff) + HEX'(1) >= HEX'(eff_h_ff));
      out_wrap    = out_col_end & out_row_end;
      out_row_nx  = out_row_ff;
      out_m3_nx   = out_m3_ff;
      out_col_nx  = out_col_ff + ColW'(1);
      if (out_col_end) begin
         out_col_nx = '0;
         if (out_row_end) begin
            out_row_nx = '0;
            out_m3_nx  = 2'd0;
         end else begin
            out_row_nx = out_row_ff + RowW'(1);
            out_m3_nx  = slot_next(out_m3_ff);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Neighbor walk: one store read per cycle
   // ---------------------------------------------------------------------
   logic [HEX-1:0] nb_row;
   logic [WEX-1:0] nb_col;
   logic           nb_row_ok, nb_col_ok, nb_byp;
   sel_type        nb_sel;
   logic [AW-1:0]  rd_addr;
   logic           mem_re;

   always_comb begin
      nb_row    = HEX'(out_row_ff) + HEX'(dr_ff) - HEX'(1);
      nb_col    = WEX'(out_col_ff) + WEX'(dc_ff) - WEX'(1);
      nb_row_ok = ~((out_row_ff == '0) && (dr_ff == 2'd0)) &&
                  (nb_row < HEX'(eff_h_ff));
      nb_col_ok = ~((out_col_ff == '0) && (dc_ff == 2'd0)) &&
                  (nb_col < WEX'(eff_w_ff));
      // The pixel in hand is not in the store yet.
      nb_byp    = (kind_ff == bb3_pkg::KIND_PIXEL) &&
                  (nb_row == HEX'(in_row_ff)) && (nb_col == WEX'(in_col_ff));
      if (!(nb_row_ok && nb_col_ok)) begin
         nb_sel = SEL_NONE;
      end else if (nb_byp) begin
         nb_sel = SEL_BYP;
      end else begin
         nb_sel = SEL_MEM;
      end
      rd_addr   = line_addr(slot_offset(out_m3_ff, dr_ff), nb_col[ColW-1:0]);
      rd_sel_in = (state_ff == ST_READ) ? nb_sel : SEL_NONE;
      mem_re    = (state_ff == ST_READ) && (nb_sel == SEL_MEM);
   end

   // ---------------------------------------------------------------------
   // Line store: one read port, one write port
   // ---------------------------------------------------------------------
   logic                           mem_we;
   logic [AW-1:0]                  wr_addr;
   logic [bb3_pkg::PIX_BUS_W-1:0]  wr_data;

   assign mem_we  = plain_write | (done_fire & (kind_ff == bb3_pkg::KIND_PIXEL));
   assign wr_addr = line_addr(in_m3_ff, in_col_ff);
   assign wr_data = (state_ff == ST_DONE) ? pix_ff : req_tdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Accumulate one neighbor per cycle, in the cycle after its read
   // ---------------------------------------------------------------------
   logic [bb3_pkg::PIX_BUS_W-1:0] acc_pix;
   logic                          blur_start;

   assign blur_start = req_fire & need_blur;
   assign acc_pix    = (rd_sel_ff == SEL_BYP) ? pix_ff : rd_data_ff;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (blur_start) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (rd_sel_ff != SEL_NONE) begin
         for (int i = 0; i < bb3_pkg::CH_N; i++) begin
            sum_in[i] = sum_ff[i] +
                        bb3_pkg::SUM_W'(acc_pix[i*bb3_pkg::PIX_W +: bb3_pkg::PIX_W]);
         end
         cnt_in = cnt_ff + bb3_pkg::CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Rounded mean: (2*sum + count) / (2*count) per channel
   // ---------------------------------------------------------------------
   bb3_pkg::lane_num_type          div_num;
   bb3_pkg::lane_num_type          div_quot;
   logic [bb3_pkg::DEN_W-1:0]      div_den;
   bb3_pkg::div_stat_type          div_stat;
   logic                           div_start;
   logic [bb3_pkg::PIX_BUS_W-1:0]  blur_pix;

   always_comb begin
      for (int i = 0; i < bb3_pkg::CH_N; i++) begin
         div_num[i] = bb3_pkg::NUM_W'({sum_ff[i], 1'b0}) + bb3_pkg::NUM_W'(cnt_ff);
      end
   end

   assign div_den   = bb3_pkg::DEN_W'({cnt_ff, 1'b0});
   assign div_start = (state_ff == ST_LOAD);

   bb3_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   // An empty window gives black; the cap at full scale is kept for safety.
   always_comb begin
      for (int i = 0; i < bb3_pkg::CH_N; i++) begin
         if (cnt_ff == '0) begin
            blur_pix[i*bb3_pkg::PIX_W +: bb3_pkg::PIX_W] = '0;
         end else if (div_quot[i] > bb3_pkg::NUM_W'(bb3_pkg::PIX_MAX)) begin
            blur_pix[i*bb3_pkg::PIX_W +: bb3_pkg::PIX_W] = bb3_pkg::PIX_MAX;
         end else begin
            blur_pix[i*bb3_pkg::PIX_W +: bb3_pkg::PIX_W] = div_quot[i][bb3_pkg::PIX_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      dr_in    = dr_ff;
      dc_in    = dc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (blur_start) begin
               state_in = ST_READ;
               dr_in    = 2'd0;
               dc_in    = 2'd0;
            end
         end
         ST_READ: begin
            if (dc_ff == 2'd2) begin
               dc_in = 2'd0;
               if (dr_ff == 2'd2) begin
                  state_in = ST_SUM;
               end else begin
                  dr_in = dr_ff + 2'd1;
               end
            end else begin
               dc_in = dc_ff + 2'd1;
            end
         end
         ST_SUM:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Position and frame bookkeeping at the end of each item.
   logic adv_in, adv_out;

   assign adv_in  = plain_write | (done_fire & (kind_ff == bb3_pkg::KIND_PIXEL));
   assign adv_out = done_fire;

   always_comb begin
      in_row_in     = adv_in  ? in_row_nx  : in_row_ff;
      in_col_in     = adv_in  ? in_col_nx  : in_col_ff;
      in_m3_in      = adv_in  ? in_m3_nx   : in_m3_ff;
      out_row_in    = adv_out ? out_row_nx : out_row_ff;
      out_col_in    = adv_out ? out_col_nx : out_col_ff;
      out_m3_in     = adv_out ? out_m3_nx  : out_m3_ff;
      frame_done_in = frame_done_ff;
      if (adv_out && (kind_ff == bb3_pkg::KIND_DRAIN) && out_wrap) begin
         frame_done_in = 1'b0;
      end
      if (adv_in && in_wrap) begin
         frame_done_in = 1'b1;
      end
   end

   // Frame size registers, held as clamped effective sizes.
   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_we && (csr_index == bb3_pkg::CFG_FRAME_WIDTH)) begin
         if (csr_wdata[bb3_pkg::FW_W-1:0] == '0) begin
            eff_w_in = WEW'(1);
         end else if (32'(csr_wdata[bb3_pkg::FW_W-1:0]) > 32'(MAX_WIDTH)) begin
            eff_w_in = WEW'(MAX_WIDTH);
         end else begin
            eff_w_in = WEW'(csr_wdata[bb3_pkg::FW_W-1:0]);
         end
      end
      if (csr_we && (csr_index == bb3_pkg::CFG_FRAME_HEIGHT)) begin
         if (csr_wdata[bb3_pkg::FH_W-1:0] == '0) begin
            eff_h_in = HEW'(1);
         end else if (32'(csr_wdata[bb3_pkg::FH_W-1:0]) > 32'(MAX_HEIGHT)) begin
            eff_h_in = HEW'(MAX_HEIGHT);
         end else begin
            eff_h_in = HEW'(csr_wdata[bb3_pkg::FH_W-1:0]);
         end
      end
   end

   // Output register.
   assign rsp_tvalid_in = done_fire | (rsp_tvalid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eff_w_ff      <= WEW'(1);
         eff_h_ff      <= HEW'(1);
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         in_m3_ff      <= 2'd0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         out_m3_ff     <= 2'd0;
         frame_done_ff <= 1'b0;
         dr_ff         <= 2'd0;
         dc_ff         <= 2'd0;
         rd_sel_ff     <= SEL_NONE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eff_w_ff      <= eff_w_in;
         eff_h_ff      <= eff_h_in;
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         in_m3_ff      <= in_m3_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         out_m3_ff     <= out_m3_in;
         frame_done_ff <= frame_done_in;
         dr_ff         <= dr_in;
         dc_ff         <= dc_in;
         rd_sel_ff     <= rd_sel_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Item payload, sums and result word.
   always_ff @(posedge clock) begin
      if (blur_start) begin
         kind_ff <= req_kind;
         pix_ff  <= req_tdata;
      end
      sum_ff <= sum_in;
      if (done_fire) begin
         rsp_tdata_ff <= blur_pix;
         rsp_tlast_ff <= out_wrap;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The store is never read and written in the same cycle.
   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("line store read and write collide");

   // The divider is started only when it has finished the previous word.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !div_stat.busy)
      else $error("divider started while busy");

   // A window never holds more than nine neighbors.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bb3_pkg::CNT_W'(bb3_pkg::NB_N))
      else $error("neighbor count out of range");

   // A mean of 8-bit values never exceeds full scale.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && div_stat.done && (cnt_ff != '0)) |->
      ((div_quot[0] <= bb3_pkg::NUM_W'(bb3_pkg::PIX_MAX)) &&
       (div_quot[1] <= bb3_pkg::NUM_W'(bb3_pkg::PIX_MAX)) &&
       (div_quot[2] <= bb3_pkg::NUM_W'(bb3_pkg::PIX_MAX))))
      else $error("divider quotient above full scale");

   // A finished result always lands in the output register.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> rsp_tvalid_ff)
      else $error("finished result not presented");

endmodule

@@ tb/tb_box_blur_3x3_edge_aware.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_box_blur_3x3_edge_aware
// Self-checking testbench for the edge-aware 3x3 box blur. A software copy
// of the blur keeps its own line store and raster counters, predicts every
// output word from the accepted input words, and compares each output word
// field by field. Directed frames cover reset size, size clamping, drain
// and pixel words outside their phase and size changes within a frame;
// random frames follow under three idling patterns.
// ============================================================================
module tb_box_blur_3x3_edge_aware;

   localparam int MAX_W = bb3_pkg::MAX_WIDTH_DEF;
   localparam int MAX_H = bb3_pkg::MAX_HEIGHT_DEF;
   localparam int PW    = bb3_pkg::PIX_W;
   localparam int BW    = bb3_pkg::PIX_BUS_W;
   localparam int RANDOM_WORDS = 380;
   localparam int SETTLE_CYCLES = 30;

   // One predicted output word.
   typedef struct packed {
      logic [PW-1:0] red;
      logic [PW-1:0] green;
      logic [PW-1:0] blue;
      logic          last;
   } blur_pixel_type;

   typedef struct packed {
      bit [31:0] row;
      bit [31:0] col;
   } raster_pos_type;

   // Tracks the frame state of the block and checks its output words.
   class blur_predictor_type;
      bit [BW-1:0]                 line_mem [3*MAX_W];
      bit [bb3_pkg::FW_W-1:0]      width_reg;
      bit [bb3_pkg::FH_W-1:0]      height_reg;
      raster_pos_type              in_pos;
      raster_pos_type              out_pos;
      bit                          frame_done;
      blur_pixel_type              expected_pixels [$];
      int                          errors;

      function new();
         width_reg  = 1;
         height_reg = 1;
         in_pos     = '0;
         out_pos    = '0;
         frame_done = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(logic [bb3_pkg::CSR_IDX_W-1:0] idx,
                              logic [bb3_pkg::CSR_DATA_W-1:0] value);
         if (idx == bb3_pkg::CFG_FRAME_WIDTH)
            width_reg = value[bb3_pkg::FW_W-1:0];
         else
            height_reg = value[bb3_pkg::FH_W-1:0];
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_H) return MAX_H;
         return height_reg;
      endfunction

      // Next raster position; it comes back to the origin only at frame end.
      function raster_pos_type next_pos(raster_pos_type p, int unsigned w,
                                        int unsigned h);
         raster_pos_type n;
         n = p;
         if (p.col + 1 >= w) begin
            n.col = 0;
            n.row = (p.row + 1 >= h) ? 0 : p.row + 1;
         end else begin
            n.col = p.col + 1;
         end
         return n;
      endfunction

      // Rounded mean of the in-frame neighbors; the pixel arriving now is
      // taken from the input word instead of the line store.
      function blur_pixel_type blur_window(raster_pos_type c, bit bypass,
                                           bit [BW-1:0] pix,
                                           int unsigned w, int unsigned h);
         int             nr, nc, count, dr, dc, ch, q;
         int             sum [bb3_pkg::CH_N];
         bit [BW-1:0]    v;
         int             lane [bb3_pkg::CH_N];
         blur_pixel_type r;
         count = 0;
         for (ch = 0; ch < bb3_pkg::CH_N; ch++) sum[ch] = 0;
         for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
               nr = int'(c.row) + dr;
               nc = int'(c.col) + dc;
               if (nr < 0 || nr >= int'(h) || nc < 0 || nc >= int'(w)) continue;
               if (bypass && nr == int'(in_pos.row) && nc == int'(in_pos.col))
                  v = pix;
               else
                  v = line_mem[(nr % 3) * MAX_W + nc];
               for (ch = 0; ch < bb3_pkg::CH_N; ch++) sum[ch] += v[PW*ch +: PW];
               count++;
            end
         end
         for (ch = 0; ch < bb3_pkg::CH_N; ch++) begin
            q = (count == 0) ? 0 : (2 * sum[ch] + count) / (2 * count);
            lane[ch] = (q > 255) ? 255 : q;
         end
         r.blue  = lane[0][PW-1:0];
         r.green = lane[1][PW-1:0];
         r.red   = lane[2][PW-1:0];
         r.last  = 1'b0;
         return r;
      endfunction

      // Called for every input word the block accepts.
      function void note_word(logic kind, bit [BW-1:0] pix);
         int unsigned       w, h;
         longint unsigned   pos;
         blur_pixel_type    r;
         w = eff_width();
         h = eff_height();
         if (kind == bb3_pkg::KIND_DRAIN) begin
            if (!frame_done) return;
            r = blur_window(out_pos, 1'b0, '0, w, h);
            out_pos = next_pos(out_pos, w, h);
            r.last = (out_pos == '0);
            if (r.last) frame_done = 1'b0;
            expected_pixels.push_back(r);
         end else begin
            // A pixel word after the frame has fully arrived is dropped.
            if (frame_done) return;
            pos = longint'(in_pos.row) * w + in_pos.col;
            if (pos >= longint'(w) + 1) begin
               r = blur_window(out_pos, 1'b1, pix, w, h);
               out_pos = next_pos(out_pos, w, h);
               r.last = (out_pos == '0);
               expected_pixels.push_back(r);
            end
            line_mem[(in_pos.row % 3) * MAX_W + in_pos.col % MAX_W] = pix;
            in_pos = next_pos(in_pos, w, h);
            if (in_pos == '0) frame_done = 1'b1;
         end
      endfunction

      // Called for every output word the block hands over.
      function void check_result(logic [BW-1:0] data, logic last);
         blur_pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: output word %h last %b arrived with none outstanding",
                        $realtime, data, last);
            return;
         end
         want = expected_pixels.pop_front();
         if (data[7:0] !== want.blue || data[15:8] !== want.green ||
             data[23:16] !== want.red || last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("%0t: expected r %h g %h b %h last %b, got r %h g %h b %h last %b",
                        $realtime, want.red, want.green, want.blue, want.last,
                        data[23:16], data[15:8], data[7:0], last);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [BW-1:0]                     req_tdata  = '0;   // blue_in, green_in, red_in
   logic [0:0]                        req_tuser  = bb3_pkg::KIND_PIXEL;   // kind
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [BW-1:0]                     rsp_tdata;         // blue_out, green_out, red_out
   logic                              rsp_tlast;
   logic                              csr_we     = 1'b0;
   logic [bb3_pkg::CSR_IDX_W-1:0]     csr_index  = bb3_pkg::CFG_FRAME_WIDTH;
   logic [bb3_pkg::CSR_DATA_W-1:0]    csr_wdata  = '0;

   int send_idle_pct = 32;
   int rcv_idle_pct  = 57;
   int useful_words  = 0;

   blur_predictor_type board = new();

   box_blur_3x3_edge_aware dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Every output word taken is checked at once.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast);
   end

   function automatic logic [PW-1:0] rand_level();
      case ($urandom_range(7))
         0: return '0;
         1: return bb3_pkg::PIX_MAX;
         default: return PW'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [BW-1:0] rand_pixel();
      return {rand_level(), rand_level(), rand_level()};
   endfunction

   // Offers one input word, with random gaps before it; returns at the
   // falling edge after it was accepted.
   task automatic send_word(input logic kind, input logic [BW-1:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(kind, pix);
      @(negedge clock);
   endtask

   // Holds the sender until every predicted word has come out.
   task automatic drain_results(input int settle);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bb3_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bb3_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Completes the current frame: pixels until it has arrived, then drain
   // ticks until its last word is out. With noise, stray drain ticks fall
   // inside the frame, stray pixels inside the drain and the sender pauses.
   task automatic run_frame(input bit noisy);
      while (!board.frame_done) begin
         if (noisy && $urandom_range(19) == 0) begin
            send_word(bb3_pkg::KIND_DRAIN, rand_pixel());
         end else begin
            if (noisy && $urandom_range(49) == 0) drain_results(1);
            send_word(bb3_pkg::KIND_PIXEL, rand_pixel());
            useful_words++;
         end
      end
      while (board.frame_done) begin
         if (noisy && $urandom_range(11) == 0) begin
            send_word(bb3_pkg::KIND_PIXEL, rand_pixel());
         end else begin
            send_word(bb3_pkg::KIND_DRAIN, rand_pixel());
            useful_words++;
         end
      end
   endtask

   function automatic logic [bb3_pkg::CSR_DATA_W-1:0] pick_width();
      case ($urandom_range(15))
         0: return '0;
         1: return bb3_pkg::CSR_DATA_W'($urandom_range(11, 32));
         default: return bb3_pkg::CSR_DATA_W'($urandom_range(1, 10));
      endcase
   endfunction

   function automatic logic [bb3_pkg::CSR_DATA_W-1:0] pick_height();
      case ($urandom_range(15))
         0: return '0;
         1: return bb3_pkg::CSR_DATA_W'($urandom_range(6, 8));
         default: return bb3_pkg::CSR_DATA_W'($urandom_range(1, 5));
      endcase
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset frame is 1x1: a drain tick with nothing pending, the only pixel,
      // a pixel after the frame ended, then the flagged output word.
      send_word(bb3_pkg::KIND_DRAIN, '0);
      send_word(bb3_pkg::KIND_PIXEL, {bb3_pkg::PIX_MAX, 8'h00, bb3_pkg::PIX_MAX});
      send_word(bb3_pkg::KIND_PIXEL, 24'h5A3C81);
      send_word(bb3_pkg::KIND_DRAIN, '1);

      // 4x3 frame of extreme levels; the width write has its upper bits set,
      // which the block masks off. This frame fills columns 0..3 of all
      // three line store rows, which later size changes rely on.
      drain_results(SETTLE_CYCLES);
      write_csr(bb3_pkg::CFG_FRAME_WIDTH, 13'h1804);
      write_csr(bb3_pkg::CFG_FRAME_HEIGHT, 13'd3);
      for (int i = 0; i < 12; i++) begin
         if (i == 6) send_word(bb3_pkg::KIND_DRAIN, '1);
         if (i == 8) drain_results(1);
         send_word(bb3_pkg::KIND_PIXEL, ((i % 2) ^ ((i / 4) % 2)) ? '1 : '0);
      end
      run_frame(1'b0);

      // Oversize width and zero height, then the width drops within the frame.
      drain_results(SETTLE_CYCLES);
      write_csr(bb3_pkg::CFG_FRAME_WIDTH, 13'd2047);
      write_csr(bb3_pkg::CFG_FRAME_HEIGHT, 13'd0);
      repeat (3) send_word(bb3_pkg::KIND_PIXEL, rand_pixel());
      drain_results(SETTLE_CYCLES);
      write_csr(bb3_pkg::CFG_FRAME_WIDTH, 13'd3);
      run_frame(1'b0);

      // Oversize height, then the height shrinks within the frame so that the
      // next output positions have no neighbor inside it.
      drain_results(SETTLE_CYCLES);
      write_csr(bb3_pkg::CFG_FRAME_WIDTH, 13'd4);
      write_csr(bb3_pkg::CFG_FRAME_HEIGHT, 13'd8191);
      repeat (13) send_word(bb3_pkg::KIND_PIXEL, rand_pixel());
      drain_results(SETTLE_CYCLES);
      write_csr(bb3_pkg::CFG_FRAME_HEIGHT, 13'd1);
      run_frame(1'b0);

      // Random frames, resized between frames, under three idling patterns.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 32; rcv_idle_pct = 57; end
            1: begin send_idle_pct = 57; rcv_idle_pct = 32; end
            default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         while (useful_words < RANDOM_WORDS * (phase + 1) / 3) begin
            drain_results(SETTLE_CYCLES);
            write_csr(bb3_pkg::CFG_FRAME_WIDTH, pick_width());
            write_csr(bb3_pkg::CFG_FRAME_HEIGHT, pick_height());
            run_frame(1'b1);
         end
      end

      drain_results(40);
      if (board.errors == 0 && board.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
